/* design/pwm_divider_wrap_level_calc_core_defines.svh */
// Assertion macros for the RTL file that checks itself.
`ifndef PWM_DIVIDER_WRAP_LEVEL_CALC_CORE_DEFINES_SVH
`define PWM_DIVIDER_WRAP_LEVEL_CALC_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define PWMDWL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pwmdwl check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define PWMDWL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pwmdwl check failed");

`endif

/* design/pwmdwl_pkg.sv */
`default_nettype none

package pwmdwl_pkg;

  localparam int unsigned CLK_W      = 30;
  localparam int unsigned DIV_W      = 32;
  localparam int unsigned LIM_W      = CLK_W + 18;
  localparam int unsigned PROD_W     = 23;
  localparam logic [29:0] CLK_RESET  = 30'd125000000;
  localparam logic [31:0] FREQ_MIN   = 32'd8;
  localparam logic [6:0]  FULL_DUTY  = 7'd100;

  // Reciprocal of 100 scaled by 2^30; exact for every product below 2^23.
  localparam logic [23:0] RECIP_100   = 24'd10737419;
  localparam int unsigned RECIP_SHIFT = 30;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_NOFIT = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DIV_SEL_CD,
    DIV_SEL_WRAP
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RANGE,
    ST_LIM_A,
    ST_LIM_B,
    ST_CD_GO,
    ST_CD_WAIT,
    ST_TEST,
    ST_W_GO,
    ST_W_WAIT,
    ST_PROD,
    ST_LEVEL,
    ST_OK,
    ST_FAIL_RANGE,
    ST_FAIL_FIT
  } state_e;

  typedef struct packed {
    logic [2:0]  slice;
    logic        channel;
    logic [31:0] target_freq_hz;
    logic [6:0]  duty_percent;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [2:0]  slice_out;
    logic        channel_out;
    logic [7:0]  clock_divider;
    logic [15:0] wrap_value;
    logic [15:0] compare_level;
    logic        enable;
  } res_t;

  typedef struct packed {
    logic     load;
    logic     lim_a;
    logic     lim_b;
    logic     div_start;
    div_sel_e div_sel;
    logic     cd_cap;
    logic     d_inc;
    logic     w_cap;
    logic     prod;
    logic     lvl_cap;
    logic     emit;
    status_e  emit_status;
  } cmd_t;

  typedef struct packed {
    logic range_bad;
    logic fits;
    logic d_last;
    logic div_done;
  } sts_t;

endpackage

`default_nettype wire

/* design/pwmdwl_sdiv.sv */
`default_nettype none

module pwmdwl_sdiv (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [pwmdwl_pkg::DIV_W-1:0]   dividend_i,
  input  wire logic [pwmdwl_pkg::DIV_W-1:0]   divisor_i,
  output logic                                done_o,
  output logic [pwmdwl_pkg::DIV_W-1:0]        quotient_o
);

  localparam int unsigned W   = pwmdwl_pkg::DIV_W;
  localparam int unsigned CNT = $clog2(W + 1);

  logic [W-1:0]   rem_q, rem_d, quo_q, quo_d, dvs_q;
  logic [CNT-1:0] cnt_q, cnt_d;
  logic           run_q, run_d, done_q, done_d;
  logic [W:0]     shifted, diff;
  logic           ge;

  always_comb begin
    shifted = {rem_q, quo_q[W-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = '0;
      quo_d = dividend_i;
      cnt_d = CNT'(W);
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d = ge ? diff[W-1:0] : shifted[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q - CNT'(1);
      if (cnt_q == CNT'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* design/pwmdwl_ctrl.sv */
`default_nettype none

module pwmdwl_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire pwmdwl_pkg::sts_t   sts_i,
  output pwmdwl_pkg::cmd_t        cmd_o,
  output logic                    busy_o
);

  pwmdwl_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pwmdwl_pkg::ST_IDLE: begin
        if (start_i) begin
          state_d = pwmdwl_pkg::ST_RANGE;
        end
      end
      pwmdwl_pkg::ST_RANGE: begin
        state_d = sts_i.range_bad ? pwmdwl_pkg::ST_FAIL_RANGE : pwmdwl_pkg::ST_LIM_A;
      end
      pwmdwl_pkg::ST_LIM_A:   state_d = pwmdwl_pkg::ST_LIM_B;
      pwmdwl_pkg::ST_LIM_B:   state_d = pwmdwl_pkg::ST_CD_GO;
      pwmdwl_pkg::ST_CD_GO:   state_d = pwmdwl_pkg::ST_CD_WAIT;
      pwmdwl_pkg::ST_CD_WAIT: begin
        if (sts_i.div_done) begin
          state_d = pwmdwl_pkg::ST_TEST;
        end
      end
      pwmdwl_pkg::ST_TEST: begin
        if (sts_i.fits) begin
          state_d = pwmdwl_pkg::ST_W_GO;
        end else if (sts_i.d_last) begin
          state_d = pwmdwl_pkg::ST_FAIL_FIT;
        end else begin
          state_d = pwmdwl_pkg::ST_CD_GO;
        end
      end
      pwmdwl_pkg::ST_W_GO:    state_d = pwmdwl_pkg::ST_W_WAIT;
      pwmdwl_pkg::ST_W_WAIT: begin
        if (sts_i.div_done) begin
          state_d = pwmdwl_pkg::ST_PROD;
        end
      end
      pwmdwl_pkg::ST_PROD:    state_d = pwmdwl_pkg::ST_LEVEL;
      pwmdwl_pkg::ST_LEVEL:   state_d = pwmdwl_pkg::ST_OK;
      pwmdwl_pkg::ST_OK,
      pwmdwl_pkg::ST_FAIL_RANGE,
      pwmdwl_pkg::ST_FAIL_FIT: state_d = pwmdwl_pkg::ST_IDLE;
      default:                 state_d = pwmdwl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.div_sel     = pwmdwl_pkg::DIV_SEL_CD;
    cmd_o.emit_status = pwmdwl_pkg::STATUS_OK;
    busy_o            = 1'b1;
    unique case (state_q)
      pwmdwl_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      pwmdwl_pkg::ST_LIM_A: cmd_o.lim_a = 1'b1;
      pwmdwl_pkg::ST_LIM_B: cmd_o.lim_b = 1'b1;
      pwmdwl_pkg::ST_CD_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = pwmdwl_pkg::DIV_SEL_CD;
      end
      pwmdwl_pkg::ST_CD_WAIT: cmd_o.cd_cap = sts_i.div_done;
      pwmdwl_pkg::ST_TEST:    cmd_o.d_inc  = !sts_i.fits && !sts_i.d_last;
      pwmdwl_pkg::ST_W_GO: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = pwmdwl_pkg::DIV_SEL_WRAP;
      end
      pwmdwl_pkg::ST_W_WAIT:  cmd_o.w_cap   = sts_i.div_done;
      pwmdwl_pkg::ST_PROD:    cmd_o.prod    = 1'b1;
      pwmdwl_pkg::ST_LEVEL:   cmd_o.lvl_cap = 1'b1;
      pwmdwl_pkg::ST_OK: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = pwmdwl_pkg::STATUS_OK;
      end
      pwmdwl_pkg::ST_FAIL_RANGE: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = pwmdwl_pkg::STATUS_RANGE;
      end
      pwmdwl_pkg::ST_FAIL_FIT: begin
        cmd_o.emit        = 1'b1;
        cmd_o.emit_status = pwmdwl_pkg::STATUS_NOFIT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwmdwl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

/* design/pwmdwl_dp.sv */
`default_nettype none

module pwmdwl_dp #(
  parameter int unsigned DIVIDER_LIMIT = 255,
  parameter int unsigned COUNTER_MAX   = 65535
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire pwmdwl_pkg::in_t                in_item_i,
  input  wire logic                           cfg_we_i,
  input  wire logic [pwmdwl_pkg::CLK_W-1:0]   cfg_data_i,
  input  wire pwmdwl_pkg::cmd_t               cmd_i,
  output pwmdwl_pkg::sts_t                    sts_o,
  output logic                                result_valid_o,
  output pwmdwl_pkg::res_t                    result_o
);

  localparam int unsigned CW = pwmdwl_pkg::CLK_W;
  localparam int unsigned LW = pwmdwl_pkg::LIM_W;
  localparam int unsigned DW = pwmdwl_pkg::DIV_W;
  localparam int unsigned PW = pwmdwl_pkg::PROD_W;
  localparam int unsigned RW = PW + 24;
  localparam logic [16:0] CMAX   = 17'(COUNTER_MAX);
  localparam logic [16:0] CMAX1  = 17'(COUNTER_MAX + 1);
  localparam logic [7:0]  D_LAST = 8'(DIVIDER_LIMIT - 1);

  pwmdwl_pkg::in_t  in_q;
  pwmdwl_pkg::res_t res_q;
  logic [6:0]       duty_q;
  logic [CW-1:0]    clk_q, cd_q, freq_lo;
  logic [7:0]       d_q;
  logic [LW-1:0]    lim_a_q, lim_b_q, mul_res;
  logic [CW:0]      mul_a;
  logic [16:0]      mul_b;
  logic [15:0]      wrap_q, level_q, base;
  logic [PW-1:0]    prod_q;
  logic [RW-1:0]    lvl_mul;
  logic             valid_q;
  logic [DW-1:0]    div_dividend, div_divisor, div_quo;
  logic             div_done;

  assign freq_lo = in_q.target_freq_hz[CW-1:0];

  always_comb begin
    mul_a = cmd_i.lim_a ? ({1'b0, freq_lo} + (CW+1)'(1)) : {1'b0, freq_lo};
    mul_b = cmd_i.lim_a ? CMAX : CMAX1;
    mul_res = LW'(mul_a) * LW'(mul_b);
    base = (duty_q == pwmdwl_pkg::FULL_DUTY) ? (wrap_q + 16'd1) : wrap_q;
    lvl_mul = RW'(prod_q) * RW'(pwmdwl_pkg::RECIP_100);
  end

  always_comb begin
    div_dividend = DW'(clk_q);
    div_divisor  = DW'(d_q);
    case (cmd_i.div_sel)
      pwmdwl_pkg::DIV_SEL_WRAP: begin
        div_dividend = DW'(cd_q);
        div_divisor  = in_q.target_freq_hz;
      end
      default: ;
    endcase
  end

  pwmdwl_sdiv u_sdiv (
    .clk_i,
    .rst_ni,
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    sts_o.range_bad = (in_q.target_freq_hz < pwmdwl_pkg::FREQ_MIN) ||
                      (in_q.target_freq_hz > 32'(clk_q));
    sts_o.fits      = (LW'(cd_q) < lim_a_q) && (LW'(cd_q) < lim_b_q);
    sts_o.d_last    = d_q == D_LAST;
    sts_o.div_done  = div_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_q   <= pwmdwl_pkg::CLK_RESET;
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.emit;
      if (cfg_we_i) begin
        clk_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q   <= in_item_i;
      duty_q <= (in_item_i.duty_percent > pwmdwl_pkg::FULL_DUTY) ?
                pwmdwl_pkg::FULL_DUTY : in_item_i.duty_percent;
      d_q    <= 8'd1;
    end else if (cmd_i.d_inc) begin
      d_q <= d_q + 8'd1;
    end
    if (cmd_i.lim_a) begin
      lim_a_q <= mul_res;
    end
    if (cmd_i.lim_b) begin
      lim_b_q <= mul_res;
    end
    if (cmd_i.cd_cap) begin
      cd_q <= div_quo[CW-1:0];
    end
    if (cmd_i.w_cap) begin
      wrap_q <= div_quo[15:0];
    end
    if (cmd_i.prod) begin
      prod_q <= PW'(base) * PW'(duty_q);
    end
    if (cmd_i.lvl_cap) begin
      level_q <= lvl_mul[pwmdwl_pkg::RECIP_SHIFT +: 16];
    end
    if (cmd_i.emit) begin
      res_q.status      <= cmd_i.emit_status;
      res_q.slice_out   <= in_q.slice;
      res_q.channel_out <= in_q.channel;
      if (cmd_i.emit_status == pwmdwl_pkg::STATUS_OK) begin
        res_q.clock_divider <= d_q;
        res_q.wrap_value    <= wrap_q;
        res_q.compare_level <= level_q;
        res_q.enable        <= 1'b1;
      end else begin
        res_q.clock_divider <= '0;
        res_q.wrap_value    <= '0;
        res_q.compare_level <= '0;
        res_q.enable        <= 1'b0;
      end
    end
  end

  assign result_valid_o = valid_q;
  assign result_o       = res_q;

endmodule

`default_nettype wire

/* design/pwm_divider_wrap_level_calc_core.sv */
// A rejected frequency is reported after the range check alone; otherwise dividers from 1
// up are tried, one serial division each, until one fits or the last has failed, and a fit
// is followed by the wrap division and the level. One item at a time, set by the shared
// 32-step serial divider; the next item is accepted from the cycle its result is shown.
// The result strobe is high for one cycle and the receiver cannot stall it.
// Reset clears the controller and loads the clock register with 125000000.
`default_nettype none

module pwm_divider_wrap_level_calc_core #(
  parameter int unsigned DIVIDER_LIMIT = 255,
  parameter int unsigned COUNTER_MAX   = 65535
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire pwmdwl_pkg::in_t                in_item_i,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [pwmdwl_pkg::CLK_W-1:0]   cfg_data_i,
  output logic                                result_valid_o,
  output pwmdwl_pkg::res_t                    result_o
);

  `include "pwm_divider_wrap_level_calc_core_defines.svh"

  pwmdwl_pkg::cmd_t cmd;
  pwmdwl_pkg::sts_t sts;
  logic             cfg_we;

  assign cfg_ready_o = !busy_o;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  pwmdwl_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .start_i,
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o
  );

  pwmdwl_dp #(
    .DIVIDER_LIMIT (DIVIDER_LIMIT),
    .COUNTER_MAX   (COUNTER_MAX)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .in_item_i,
    .cfg_we_i       (cfg_we),
    .cfg_data_i,
    .cmd_i          (cmd),
    .sts_o          (sts),
    .result_valid_o,
    .result_o
  );

  `PWMDWL_ASSERT_NEXT(a_start_busy, start_i && !busy_o, busy_o)
  `PWMDWL_ASSERT_NEXT(a_single_result, result_valid_o, !result_valid_o)
  `PWMDWL_ASSERT_SAME(a_enable_ok, result_valid_o, result_o.enable == (result_o.status == pwmdwl_pkg::STATUS_OK))
  `PWMDWL_ASSERT_SAME(a_div_range, result_valid_o && result_o.enable, (result_o.clock_divider != 8'd0) && (32'(result_o.clock_divider) < DIVIDER_LIMIT))

endmodule

`default_nettype wire

/* tb/tb_pwm_divider_wrap_level_calc_core.sv */
`default_nettype none

module tb_pwm_divider_wrap_level_calc_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_W            = pwmdwl_pkg::CLK_W;
  localparam int unsigned DIVIDER_LIMIT    = 255;
  localparam int unsigned COUNTER_MAX      = 65535;
  localparam logic [CLK_W-1:0] CLK_MAX     = 30'h3FFF_FFFF;
  localparam int unsigned RANDOM_ITEMS     = 76;
  localparam int unsigned RANDOM_PHASES    = 4;
  localparam int unsigned SHOWN_MISMATCHES = 10;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 start_i        = 1'b0;
  logic                 busy_o;
  pwmdwl_pkg::in_t      in_item_i      = '0;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  logic [CLK_W-1:0]     cfg_data_i     = '0;
  logic                 result_valid_o;
  pwmdwl_pkg::res_t     result_o;

  logic [CLK_W-1:0]     clock_hz = pwmdwl_pkg::CLK_RESET;
  pwmdwl_pkg::res_t     pending_settings[$];
  pwmdwl_pkg::res_t     oldest_settings;
  int unsigned          mismatches;
  int unsigned          results_seen;
  int unsigned          sent_ok;
  int unsigned          sent_range;
  int unsigned          sent_nofit;
  int unsigned          clock_settings;
  bit                   steady;

  pwm_divider_wrap_level_calc_core #(
    .DIVIDER_LIMIT(DIVIDER_LIMIT),
    .COUNTER_MAX  (COUNTER_MAX)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .in_item_i     (in_item_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic pwmdwl_pkg::res_t calc_settings(input pwmdwl_pkg::in_t req,
                                                     input logic [CLK_W-1:0] clk_hz);
    logic [31:0]      clk32;
    logic [31:0]      freq;
    logic [31:0]      cd;
    logic [31:0]      w;
    logic [31:0]      base;
    logic [31:0]      prod;
    logic [6:0]       duty;
    int unsigned      d;
    bit               found;
    pwmdwl_pkg::res_t r;
    r = '0;
    r.slice_out   = req.slice;
    r.channel_out = req.channel;
    clk32 = {2'b00, clk_hz};
    freq  = req.target_freq_hz;
    duty  = (req.duty_percent > pwmdwl_pkg::FULL_DUTY) ? pwmdwl_pkg::FULL_DUTY
                                                       : req.duty_percent;
    if (freq < pwmdwl_pkg::FREQ_MIN || freq > clk32) begin
      r.status = pwmdwl_pkg::STATUS_RANGE;
      return r;
    end
    found = 1'b0;
    w = '0;
    for (d = 1; d < DIVIDER_LIMIT && !found; d++) begin
      cd = clk32 / d;
      w  = cd / freq;
      if (cd / COUNTER_MAX <= freq && w <= COUNTER_MAX) begin
        found           = 1'b1;
        r.clock_divider = d[7:0];
        r.wrap_value    = w[15:0];
      end
    end
    if (!found) begin
      r.status = pwmdwl_pkg::STATUS_NOFIT;
      return r;
    end
    base = (duty == pwmdwl_pkg::FULL_DUTY) ? w + 32'd1 : w;
    base = base & 32'h0000_FFFF;
    prod = base * {25'd0, duty};
    r.compare_level = 16'(prod / {25'd0, pwmdwl_pkg::FULL_DUTY});
    r.enable        = 1'b1;
    r.status        = pwmdwl_pkg::STATUS_OK;
    return r;
  endfunction

  function automatic pwmdwl_pkg::in_t make_request(input int unsigned slice,
                                                   input int unsigned channel,
                                                   input logic [31:0] freq,
                                                   input int unsigned duty);
    pwmdwl_pkg::in_t req;
    req.slice          = 3'(slice);
    req.channel        = 1'(channel);
    req.target_freq_hz = freq;
    req.duty_percent   = 7'(duty);
    return req;
  endfunction

  function automatic pwmdwl_pkg::in_t random_request();
    pwmdwl_pkg::in_t req;
    logic [31:0]     top;
    logic [31:0]     f;
    int unsigned     k;
    req.slice        = 3'($urandom_range(0, 7));
    req.channel      = 1'($urandom_range(0, 1));
    req.duty_percent = ($urandom_range(99) < 85) ? 7'($urandom_range(0, 100))
                                                 : 7'($urandom_range(101, 127));
    if ($urandom_range(99) < 85) begin
      k   = $urandom_range(0, 26);
      top = {2'b00, clock_hz} >> k;
      f   = top - ($urandom % (top / 8 + 1));
      if (f < pwmdwl_pkg::FREQ_MIN) f = pwmdwl_pkg::FREQ_MIN;
    end else begin
      case ($urandom_range(0, 2))
        0:       f = $urandom;
        1:       f = $urandom_range(0, 7);
        default: f = {2'b00, clock_hz} + $urandom_range(1, 1000);
      endcase
    end
    req.target_freq_hz = f;
    return req;
  endfunction

  function automatic bit same_settings(input pwmdwl_pkg::res_t a, input pwmdwl_pkg::res_t b);
    return a.status === b.status && a.slice_out === b.slice_out &&
           a.channel_out === b.channel_out && a.clock_divider === b.clock_divider &&
           a.wrap_value === b.wrap_value && a.compare_level === b.compare_level &&
           a.enable === b.enable;
  endfunction

  function automatic void note_mismatch(input string what, input pwmdwl_pkg::res_t want,
                                        input pwmdwl_pkg::res_t got);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES) begin
      $display("%0t: %s: expected status=%0d slice=%0d ch=%0d div=%0d wrap=%0d level=%0d en=%0d",
               $realtime, what, want.status, want.slice_out, want.channel_out,
               want.clock_divider, want.wrap_value, want.compare_level, want.enable);
      $display("%0t: %s: got      status=%0d slice=%0d ch=%0d div=%0d wrap=%0d level=%0d en=%0d",
               $realtime, what, got.status, got.slice_out, got.channel_out,
               got.clock_divider, got.wrap_value, got.compare_level, got.enable);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_settings.size() == 0) begin
        note_mismatch("unexpected result", '0, result_o);
      end else begin
        oldest_settings = pending_settings.pop_front();
        if (!same_settings(oldest_settings, result_o)) begin
          note_mismatch("wrong result", oldest_settings, result_o);
        end
      end
    end
  end

  task automatic send_request(input pwmdwl_pkg::in_t req);
    int unsigned      gap;
    pwmdwl_pkg::res_t want;
    gap = 0;
    if (!steady && $urandom_range(99) < 32) gap = $urandom_range(1, 120);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i   <= 1'b1;
    in_item_i <= req;
    do @(posedge clk_i); while (busy_o);
    want = calc_settings(req, clock_hz);
    pending_settings.push_back(want);
    case (want.status)
      pwmdwl_pkg::STATUS_OK:    sent_ok++;
      pwmdwl_pkg::STATUS_RANGE: sent_range++;
      default:                  sent_nofit++;
    endcase
  endtask

  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_settings.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_clock(input logic [CLK_W-1:0] hz);
    if (!steady && $urandom_range(99) < 32) repeat ($urandom_range(1, 8)) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= hz;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    clock_hz = hz;
    clock_settings++;
  endtask

  task automatic test_frequency_range();
    send_request(make_request(0, 0, 32'd0, 50));
    send_request(make_request(7, 1, 32'd7, 50));
    send_request(make_request(1, 0, 32'd8, 50));
    send_request(make_request(2, 1, 32'd1907, 50));
    send_request(make_request(3, 0, 32'd1908, 50));
    send_request(make_request(4, 1, 32'd125_000_000, 50));
    send_request(make_request(5, 0, 32'd125_000_001, 50));
    send_request(make_request(6, 1, 32'hFFFF_FFFF, 127));
    wait_idle();
  endtask

  task automatic test_duty_levels();
    send_request(make_request(7, 1, 32'd1000, 0));
    send_request(make_request(0, 0, 32'd1000, 1));
    send_request(make_request(7, 0, 32'd1000, 99));
    send_request(make_request(0, 1, 32'd1000, 100));
    send_request(make_request(7, 1, 32'd1000, 101));
    send_request(make_request(5, 0, 32'd1000, 127));
    wait_idle();
  endtask

  task automatic test_full_scale_wrap();
    write_clock(30'd524_280);
    send_request(make_request(1, 1, 32'd8, 100));
    send_request(make_request(2, 0, 32'd8, 127));
    send_request(make_request(3, 1, 32'd8, 99));
    wait_idle();
  endtask

  task automatic test_no_divider_fits();
    write_clock(CLK_MAX);
    send_request(make_request(4, 0, 32'd8, 50));
    send_request(make_request(5, 1, 32'd16, 100));
    send_request(make_request(6, 0, 32'd100_000, 100));
    wait_idle();
  endtask

  task automatic test_clock_extremes();
    write_clock('0);
    send_request(make_request(0, 1, 32'd8, 50));
    send_request(make_request(7, 0, 32'd0, 50));
    wait_idle();
    write_clock(30'd1);
    send_request(make_request(3, 0, 32'd1, 100));
    send_request(make_request(4, 1, 32'd8, 100));
    wait_idle();
  endtask

  task automatic test_random_requests();
    logic [CLK_W-1:0] hz;
    int unsigned      phase;
    int unsigned      n;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = (phase == 2);
      case ($urandom_range(0, 3))
        0:       hz = CLK_W'($urandom);
        1:       hz = CLK_W'($urandom_range(1000, 2_000_000));
        2:       hz = pwmdwl_pkg::CLK_RESET;
        default: hz = CLK_MAX;
      endcase
      write_clock(hz);
      for (n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) send_request(random_request());
      wait_idle();
    end
    steady = 1'b0;
  endtask

  initial begin
    steady = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_frequency_range();
    test_duty_levels();
    test_full_scale_wrap();
    test_no_divider_fits();
    test_clock_extremes();
    test_random_requests();
    repeat (20) @(posedge clk_i);
    $display("Checked %0d results over %0d clock settings: %0d fitted, %0d out of range,",
             results_seen, clock_settings + 1, sent_ok, sent_range);
    $display("%0d with no fitting divider; %0d mismatches.", sent_nofit, mismatches);
    if (mismatches == 0 && pending_settings.size() == 0) begin
      $display("tb_pwm_divider_wrap_level_calc_core: PASS");
    end else begin
      $display("tb_pwm_divider_wrap_level_calc_core: FAIL");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Timed out with %0d items still awaiting a result.", pending_settings.size());
    $display("tb_pwm_divider_wrap_level_calc_core: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/pwmdwl_pkg.sv
design/pwmdwl_sdiv.sv
design/pwmdwl_ctrl.sv
design/pwmdwl_dp.sv
design/pwm_divider_wrap_level_calc_core.sv
tb/tb_pwm_divider_wrap_level_calc_core.sv
